// File: rtl/core/stec_pkg.sv
// Shared types, constants and helpers for the SRAM test error classifier.
package stec_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NBITS_W    = 6;
  localparam int unsigned LOG_IDX_W  = 12;
  localparam int unsigned LOG_DEPTH  = 4096;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW   = QUEUE_AW + 1;

  localparam logic [NBITS_W-1:0] SINGLE_MAX_RESET = NBITS_W'(3);

  localparam logic KIND_CHECK = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [WORD_W-1:0] PAT_ZERO = 32'h0000_0000;
  localparam logic [WORD_W-1:0] PAT_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] PAT_AA   = 32'hAAAA_AAAA;
  localparam logic [WORD_W-1:0] PAT_55   = 32'h5555_5555;

  // Classified item handed from the front end to the counter stage.
  typedef struct packed {
    logic                clr;
    logic                fail;
    logic                single;
    logic [NBITS_W-1:0]  nbits;
    logic [WORD_W-1:0]   addr;
    logic [WORD_W-1:0]   last;
    logic [WORD_W-1:0]   mask;
  } item_t;

  function automatic logic [NBITS_W-1:0] popcount32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s;
    s = (v & 32'h5555_5555) + ((v >> 1) & 32'h5555_5555);
    s = (s & 32'h3333_3333) + ((s >> 2) & 32'h3333_3333);
    s = (s & 32'h0F0F_0F0F) + ((s >> 4) & 32'h0F0F_0F0F);
    s = (s & 32'h00FF_00FF) + ((s >> 8) & 32'h00FF_00FF);
    s = (s & 32'h0000_FFFF) + ((s >> 16) & 32'h0000_FFFF);
    return s[NBITS_W-1:0];
  endfunction

endpackage

// File: rtl/core/stec_in_if.sv
// Input channel: one check or clear item per transfer.
interface stec_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] word_address;
  logic [31:0] read_addr_pat;
  logic [31:0] read_inv_addr_pat;
  logic [31:0] read_zero_pat;
  logic [31:0] read_ones_pat;
  logic [31:0] read_aa_pat;
  logic [31:0] read_55_pat;

  modport source (
    output valid, kind, word_address, read_addr_pat, read_inv_addr_pat,
           read_zero_pat, read_ones_pat, read_aa_pat, read_55_pat,
    input  ready
  );
  modport sink (
    input  valid, kind, word_address, read_addr_pat, read_inv_addr_pat,
           read_zero_pat, read_ones_pat, read_aa_pat, read_55_pat,
    output ready
  );
endinterface

// File: rtl/core/stec_out_if.sv
// Result channel: one log/counter record per transfer.
interface stec_out_if;
  logic        valid;
  logic        ready;
  logic        log_valid;
  logic [11:0] log_index;
  logic [31:0] log_address;
  logic [31:0] log_word;
  logic [31:0] log_mask;
  logic [5:0]  failing_bits;
  logic [31:0] single_words;
  logic [31:0] multi_words;
  logic [31:0] bit_errors;
  logic [31:0] single_bits;
  logic [31:0] multi_bits;
  logic [31:0] checked_words;

  modport source (
    output valid, log_valid, log_index, log_address, log_word, log_mask,
           failing_bits, single_words, multi_words, bit_errors, single_bits,
           multi_bits, checked_words,
    input  ready
  );
  modport sink (
    input  valid, log_valid, log_index, log_address, log_word, log_mask,
           failing_bits, single_words, multi_words, bit_errors, single_bits,
           multi_bits, checked_words,
    output ready
  );
endinterface

// File: rtl/core/stec_front.sv
// Front end: accepts items, builds the mismatch mask and classifies the word.
module stec_front (
  input  logic                          clk,
  input  logic                          rst_n,
  stec_in_if.sink                       in_ch,
  input  logic                          cfg_we,
  input  logic [stec_pkg::NBITS_W-1:0]  cfg_wdata,
  output logic                          f_valid,
  input  logic                          f_ready,
  output stec_pkg::item_t               f_item
);

  logic [stec_pkg::NBITS_W-1:0] single_max_r;
  logic                         f_v_r;
  stec_pkg::item_t              f_item_r;
  stec_pkg::item_t              item_nxt;
  logic [stec_pkg::WORD_W-1:0]  exp_v [6];
  logic [stec_pkg::WORD_W-1:0]  rd_v  [6];
  logic [stec_pkg::WORD_W-1:0]  mask;
  logic [stec_pkg::WORD_W-1:0]  last;
  logic [stec_pkg::NBITS_W-1:0] nbits;
  logic                         accept;

  assign in_ch.ready = !f_v_r || f_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    exp_v[0] = in_ch.word_address;
    exp_v[1] = ~in_ch.word_address;
    exp_v[2] = stec_pkg::PAT_ZERO;
    exp_v[3] = stec_pkg::PAT_ONES;
    exp_v[4] = stec_pkg::PAT_AA;
    exp_v[5] = stec_pkg::PAT_55;
    rd_v[0]  = in_ch.read_addr_pat;
    rd_v[1]  = in_ch.read_inv_addr_pat;
    rd_v[2]  = in_ch.read_zero_pat;
    rd_v[3]  = in_ch.read_ones_pat;
    rd_v[4]  = in_ch.read_aa_pat;
    rd_v[5]  = in_ch.read_55_pat;
    mask = '0;
    last = '0;
    // later patterns overwrite earlier ones
    for (int p = 0; p < 6; p++) begin
      mask = mask | (rd_v[p] ^ exp_v[p]);
      if (rd_v[p] != exp_v[p]) begin
        last = rd_v[p];
      end
    end
    nbits = stec_pkg::popcount32(mask);

    item_nxt.clr    = (in_ch.kind == stec_pkg::KIND_CLEAR);
    item_nxt.fail   = (nbits != '0);
    item_nxt.single = (nbits != '0) && (nbits <= single_max_r);
    item_nxt.nbits  = nbits;
    item_nxt.addr   = in_ch.word_address;
    item_nxt.last   = last;
    item_nxt.mask   = mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_max_r <= stec_pkg::SINGLE_MAX_RESET;
      f_v_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        single_max_r <= cfg_wdata;
      end
      if (accept) begin
        f_v_r <= 1'b1;
      end else if (f_ready) begin
        f_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= item_nxt;
    end
  end

  assign f_valid = f_v_r;
  assign f_item  = f_item_r;

endmodule

// File: rtl/core/stec_queue.sv
// Short register queue between the front end and the counter stage.
module stec_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push_valid,
  output logic                           push_ready,
  input  stec_pkg::item_t                push_item,
  output logic                           pop_valid,
  input  logic                           pop_ready,
  output stec_pkg::item_t                pop_item,
  output logic [stec_pkg::QUEUE_CW-1:0]  q_count
);

  stec_pkg::item_t                 slot_r [stec_pkg::QUEUE_DEPTH];
  logic [stec_pkg::QUEUE_AW-1:0]   wr_ptr_r;
  logic [stec_pkg::QUEUE_AW-1:0]   rd_ptr_r;
  logic [stec_pkg::QUEUE_CW-1:0]   count_r;
  logic                            push;
  logic                            pop;

  assign push_ready = (count_r != stec_pkg::QUEUE_CW'(stec_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];
  assign q_count    = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + stec_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + stec_pkg::QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + stec_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - stec_pkg::QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/stec_back.sv
// Counter stage: updates the error counters and registers the result record.
module stec_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             b_valid,
  output logic             b_ready,
  input  stec_pkg::item_t  b_item,
  stec_out_if.source       out_ch
);

  localparam logic [31:0] LOG_LIMIT = 32'(stec_pkg::LOG_DEPTH);

  logic        out_v_r;
  logic [31:0] single_words_r, multi_words_r, bit_errors_r;
  logic [31:0] single_bits_r, multi_bits_r, checked_words_r;
  logic [31:0] single_words_nxt, multi_words_nxt, bit_errors_nxt;
  logic [31:0] single_bits_nxt, multi_bits_nxt, checked_words_nxt;
  logic        log_valid_r, log_valid_nxt;
  logic [stec_pkg::LOG_IDX_W-1:0] log_index_r, log_index_nxt;
  logic [31:0] log_address_r, log_word_r, log_mask_r;
  logic [31:0] log_address_nxt, log_word_nxt, log_mask_nxt;
  logic [stec_pkg::NBITS_W-1:0] failing_bits_r, failing_bits_nxt;
  logic [31:0] nbits_ext;
  logic        pop;

  assign b_ready   = !out_v_r || out_ch.ready;
  assign pop       = b_valid && b_ready;
  assign nbits_ext = {{(32 - stec_pkg::NBITS_W){1'b0}}, b_item.nbits};

  always_comb begin
    single_words_nxt  = single_words_r;
    multi_words_nxt   = multi_words_r;
    bit_errors_nxt    = bit_errors_r;
    single_bits_nxt   = single_bits_r;
    multi_bits_nxt    = multi_bits_r;
    checked_words_nxt = checked_words_r;
    log_valid_nxt     = 1'b0;
    log_index_nxt     = '0;
    log_address_nxt   = '0;
    log_word_nxt      = '0;
    log_mask_nxt      = '0;
    failing_bits_nxt  = '0;
    if (b_item.clr) begin
      single_words_nxt  = '0;
      multi_words_nxt   = '0;
      bit_errors_nxt    = '0;
      single_bits_nxt   = '0;
      multi_bits_nxt    = '0;
      checked_words_nxt = '0;
    end else begin
      checked_words_nxt = checked_words_r + 32'd1;
      failing_bits_nxt  = b_item.nbits;
      if (b_item.fail) begin
        bit_errors_nxt = bit_errors_r + nbits_ext;
        if (b_item.single) begin
          // log only while slots remain
          if (single_words_r < LOG_LIMIT) begin
            log_valid_nxt   = 1'b1;
            log_index_nxt   = single_words_r[stec_pkg::LOG_IDX_W-1:0];
            log_address_nxt = b_item.addr;
            log_word_nxt    = b_item.last;
            log_mask_nxt    = b_item.mask;
          end
          single_words_nxt = single_words_r + 32'd1;
          single_bits_nxt  = single_bits_r + nbits_ext;
        end else begin
          multi_words_nxt = multi_words_r + 32'd1;
          multi_bits_nxt  = multi_bits_r + nbits_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r         <= 1'b0;
      single_words_r  <= '0;
      multi_words_r   <= '0;
      bit_errors_r    <= '0;
      single_bits_r   <= '0;
      multi_bits_r    <= '0;
      checked_words_r <= '0;
    end else begin
      if (pop) begin
        out_v_r         <= 1'b1;
        single_words_r  <= single_words_nxt;
        multi_words_r   <= multi_words_nxt;
        bit_errors_r    <= bit_errors_nxt;
        single_bits_r   <= single_bits_nxt;
        multi_bits_r    <= multi_bits_nxt;
        checked_words_r <= checked_words_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      log_valid_r    <= log_valid_nxt;
      log_index_r    <= log_index_nxt;
      log_address_r  <= log_address_nxt;
      log_word_r     <= log_word_nxt;
      log_mask_r     <= log_mask_nxt;
      failing_bits_r <= failing_bits_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.log_valid     = log_valid_r;
  assign out_ch.log_index     = log_index_r;
  assign out_ch.log_address   = log_address_r;
  assign out_ch.log_word      = log_word_r;
  assign out_ch.log_mask      = log_mask_r;
  assign out_ch.failing_bits  = failing_bits_r;
  assign out_ch.single_words  = single_words_r;
  assign out_ch.multi_words   = multi_words_r;
  assign out_ch.bit_errors    = bit_errors_r;
  assign out_ch.single_bits   = single_bits_r;
  assign out_ch.multi_bits    = multi_bits_r;
  assign out_ch.checked_words = checked_words_r;

endmodule

// File: rtl/core/sram_test_error_classifier.sv
// Path: an item passes the front-end register, a queue slot and the result register.
// Throughput: one item per cycle while out_ch.ready holds; the mask/popcount stage
// and the counter stage each take one per cycle, joined by a four-entry queue.
// Reset (rst_n low, synchronous): counters zero, queue empty, no result valid,
// single_max_bits back to 3.
module sram_test_error_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  stec_in_if.sink                       in_ch,
  stec_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [stec_pkg::NBITS_W-1:0]  cfg_wdata
);

  logic                          f_valid;
  logic                          f_ready;
  stec_pkg::item_t               f_item;
  logic                          b_valid;
  logic                          b_ready;
  stec_pkg::item_t               b_item;
  logic [stec_pkg::QUEUE_CW-1:0] q_count;

  stec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_item    (f_item)
  );

  stec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item),
    .q_count    (q_count)
  );

  stec_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_valid (b_valid),
    .b_ready (b_ready),
    .b_item  (b_item),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= stec_pkg::QUEUE_CW'(stec_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_log_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.log_valid) |-> (out_ch.failing_bits != '0))
    else $error("log entry without failing bits");

  a_nolog_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.log_valid) |-> (out_ch.log_mask == '0))
    else $error("mask shown without log entry");

  a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count != $past(q_count)) |-> ($past(f_valid && f_ready) || $past(b_valid && b_ready)))
    else $error("queue count moved without a transfer");
`endif

endmodule

// File: dv/tb_top.sv
// Testbench for sram_test_error_classifier: random and directed reads, checked per record.
package stec_tb_pkg;
  import stec_pkg::*;

  typedef struct packed {
    logic                    kind;
    logic [WORD_W-1:0]       addr;
    logic [5:0][WORD_W-1:0]  rd;    // addr, ~addr, zeros, ones, AA, 55
  } word_check_t;

  typedef struct packed {
    logic                  log_valid;
    logic [LOG_IDX_W-1:0]  log_index;
    logic [WORD_W-1:0]     log_address;
    logic [WORD_W-1:0]     log_word;
    logic [WORD_W-1:0]     log_mask;
    logic [NBITS_W-1:0]    failing_bits;
    logic [WORD_W-1:0]     single_words;
    logic [WORD_W-1:0]     multi_words;
    logic [WORD_W-1:0]     bit_errors;
    logic [WORD_W-1:0]     single_bits;
    logic [WORD_W-1:0]     multi_bits;
    logic [WORD_W-1:0]     checked_words;
  } log_rec_t;

  class error_tally_model;
    logic [NBITS_W-1:0] max_single_bits;
    logic [WORD_W-1:0]  single_words, multi_words, bit_errors;
    logic [WORD_W-1:0]  single_bits, multi_bits, checked_words;
    log_rec_t           pending_logs[$];
    int                 mismatches;
    int                 records;

    function new();
      max_single_bits = SINGLE_MAX_RESET;
      zero_counters();
      mismatches = 0;
      records = 0;
    endfunction

    function void zero_counters();
      single_words  = '0;
      multi_words   = '0;
      bit_errors    = '0;
      single_bits   = '0;
      multi_bits    = '0;
      checked_words = '0;
    endfunction

    // Predict the record for one accepted word and queue it.
    function void absorb_word(word_check_t w);
      log_rec_t          r;
      logic [WORD_W-1:0] pat [6];
      logic [WORD_W-1:0] mask;
      logic [WORD_W-1:0] last;
      int                nbits;
      r = '0;
      if (w.kind == KIND_CLEAR) begin
        zero_counters();
      end else begin
        pat = '{w.addr, ~w.addr, PAT_ZERO, PAT_ONES, PAT_AA, PAT_55};
        mask = '0;
        last = '0;
        // later patterns overwrite the kept read
        for (int p = 0; p < 6; p++) begin
          if (w.rd[p] != pat[p]) begin
            mask |= w.rd[p] ^ pat[p];
            last = w.rd[p];
          end
        end
        nbits = $countones(mask);
        checked_words++;
        if (nbits > 0) begin
          bit_errors += nbits;
          if (nbits <= max_single_bits) begin
            if (single_words < LOG_DEPTH) begin
              r.log_valid   = 1'b1;
              r.log_index   = single_words[LOG_IDX_W-1:0];
              r.log_address = w.addr;
              r.log_word    = last;
              r.log_mask    = mask;
            end
            single_words++;
            single_bits += nbits;
          end else begin
            multi_words++;
            multi_bits += nbits;
          end
        end
        r.failing_bits = NBITS_W'(nbits);
      end
      r.single_words  = single_words;
      r.multi_words   = multi_words;
      r.bit_errors    = bit_errors;
      r.single_bits   = single_bits;
      r.multi_bits    = multi_bits;
      r.checked_words = checked_words;
      pending_logs.push_back(r);
    endfunction

    task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("[%0t] record %0d: %s got 0x%h expected 0x%h", $time, records, what, got,
               want);
      mismatches++;
    endtask

    task match_record(log_rec_t got);
      log_rec_t want;
      records++;
      if (pending_logs.size() == 0) begin
        report("record with nothing outstanding", '0, '0);
        return;
      end
      want = pending_logs.pop_front();
      if (got.log_valid !== want.log_valid)
        report("log_valid", got.log_valid, want.log_valid);
      if (got.log_index !== want.log_index)
        report("log_index", got.log_index, want.log_index);
      if (got.log_address !== want.log_address)
        report("log_address", got.log_address, want.log_address);
      if (got.log_word !== want.log_word)
        report("log_word", got.log_word, want.log_word);
      if (got.log_mask !== want.log_mask)
        report("log_mask", got.log_mask, want.log_mask);
      if (got.failing_bits !== want.failing_bits)
        report("failing_bits", got.failing_bits, want.failing_bits);
      if (got.single_words !== want.single_words)
        report("single_words", got.single_words, want.single_words);
      if (got.multi_words !== want.multi_words)
        report("multi_words", got.multi_words, want.multi_words);
      if (got.bit_errors !== want.bit_errors)
        report("bit_errors", got.bit_errors, want.bit_errors);
      if (got.single_bits !== want.single_bits)
        report("single_bits", got.single_bits, want.single_bits);
      if (got.multi_bits !== want.multi_bits)
        report("multi_bits", got.multi_bits, want.multi_bits);
      if (got.checked_words !== want.checked_words)
        report("checked_words", got.checked_words, want.checked_words);
    endtask
  endclass
endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stec_pkg::*;
  import stec_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_WORDS = 1092;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [NBITS_W-1:0] cfg_wdata;
  bit                 idle_on;
  int unsigned        cycles;
  error_tally_model   model;

  stec_in_if  in_ch ();
  stec_out_if out_ch ();

  sram_test_error_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result side: drop ready about 13 percent of the time while idling is on.
  always @(negedge clk) begin
    out_ch.ready <= !idle_on || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    word_check_t seen_word;
    log_rec_t    seen_rec;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_word.kind  = in_ch.kind;
      seen_word.addr  = in_ch.word_address;
      seen_word.rd[0] = in_ch.read_addr_pat;
      seen_word.rd[1] = in_ch.read_inv_addr_pat;
      seen_word.rd[2] = in_ch.read_zero_pat;
      seen_word.rd[3] = in_ch.read_ones_pat;
      seen_word.rd[4] = in_ch.read_aa_pat;
      seen_word.rd[5] = in_ch.read_55_pat;
      model.absorb_word(seen_word);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_rec.log_valid     = out_ch.log_valid;
      seen_rec.log_index     = out_ch.log_index;
      seen_rec.log_address   = out_ch.log_address;
      seen_rec.log_word      = out_ch.log_word;
      seen_rec.log_mask      = out_ch.log_mask;
      seen_rec.failing_bits  = out_ch.failing_bits;
      seen_rec.single_words  = out_ch.single_words;
      seen_rec.multi_words   = out_ch.multi_words;
      seen_rec.bit_errors    = out_ch.bit_errors;
      seen_rec.single_bits   = out_ch.single_bits;
      seen_rec.multi_bits    = out_ch.multi_bits;
      seen_rec.checked_words = out_ch.checked_words;
      model.match_record(seen_rec);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic word_check_t clean_word(logic [WORD_W-1:0] a);
    word_check_t w;
    w.kind  = KIND_CHECK;
    w.addr  = a;
    w.rd[0] = a;
    w.rd[1] = ~a;
    w.rd[2] = PAT_ZERO;
    w.rd[3] = PAT_ONES;
    w.rd[4] = PAT_AA;
    w.rd[5] = PAT_55;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] few_bits(int unsigned n);
    logic [WORD_W-1:0] m;
    m = '0;
    repeat (n) m[$urandom_range(WORD_W-1)] = 1'b1;
    return m;
  endfunction

  function automatic word_check_t random_word();
    word_check_t w;
    logic [WORD_W-1:0] a;
    int unsigned mode;
    a = $urandom;
    if ($urandom_range(9) == 0) a = $urandom_range(1) ? PAT_ONES : PAT_ZERO;
    w = clean_word(a);
    if ($urandom_range(99) < 3) begin
      w.kind = KIND_CLEAR;
      for (int p = 0; p < 6; p++) w.rd[p] = $urandom;
      return w;
    end
    // 0-2 clean, 3-6 sparse flips, 7-8 heavier flips, 9 garbage reads
    mode = $urandom_range(9);
    for (int p = 0; p < 6; p++) begin
      if (mode >= 3 && mode <= 6 && $urandom_range(3) == 0)
        w.rd[p] ^= few_bits($urandom_range(1, 2));
      else if (mode >= 7 && mode <= 8 && $urandom_range(1) == 0)
        w.rd[p] ^= few_bits($urandom_range(1, 8));
      else if (mode == 9)
        w.rd[p] = $urandom;
    end
    return w;
  endfunction

  task automatic send_word(word_check_t w);
    while (idle_on && $urandom_range(99) < 13) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid             <= 1'b1;
    in_ch.kind              <= w.kind;
    in_ch.word_address      <= w.addr;
    in_ch.read_addr_pat     <= w.rd[0];
    in_ch.read_inv_addr_pat <= w.rd[1];
    in_ch.read_zero_pat     <= w.rd[2];
    in_ch.read_ones_pat     <= w.rd[3];
    in_ch.read_aa_pat       <= w.rd[4];
    in_ch.read_55_pat       <= w.rd[5];
    // hold until the transfer happens
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (model.pending_logs.size() != 0) @(posedge clk);
  endtask

  // Write only with the pipe empty.
  task automatic set_threshold(logic [NBITS_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    model.max_single_bits = v;
  endtask

  initial begin
    word_check_t       w;
    logic [NBITS_W-1:0] phase_limits [7];
    model = new();
    idle_on = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_CHECK;
    in_ch.word_address = '0;
    in_ch.read_addr_pat = '0;
    in_ch.read_inv_addr_pat = '0;
    in_ch.read_zero_pat = '0;
    in_ch.read_ones_pat = '0;
    in_ch.read_aa_pat = '0;
    in_ch.read_55_pat = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset threshold.
    send_word(clean_word(PAT_ZERO));
    send_word(clean_word(PAT_ONES));
    w = clean_word(32'h1234_5678);
    w.rd[2][0] = 1'b1;
    send_word(w);
    w = clean_word(32'h8000_0001);
    w.rd[5][31] = ~w.rd[5][31];
    send_word(w);
    // three bits on three patterns: exactly at the threshold
    w = clean_word(32'hDEAD_BEEF);
    w.rd[0][5]  = ~w.rd[0][5];
    w.rd[3][17] = ~w.rd[3][17];
    w.rd[4][30] = ~w.rd[4][30];
    send_word(w);
    w = clean_word(32'h0F0F_0F0F);
    w.rd[1] ^= 32'h0000_000F;
    send_word(w);
    w = clean_word(32'h5555_AAAA);
    for (int p = 0; p < 6; p++) w.rd[p][9] = ~w.rd[p][9];
    send_word(w);
    w = clean_word(32'hC001_0FF5);
    for (int p = 0; p < 6; p++) w.rd[p] = ~w.rd[p];
    send_word(w);
    w = clean_word(32'h0000_FFFF);
    for (int p = 0; p < 6; p++) w.rd[p] = PAT_ZERO;
    send_word(w);
    w = clean_word(32'hFFFF_0000);
    for (int p = 0; p < 6; p++) w.rd[p] = PAT_ONES;
    send_word(w);
    w = clean_word(32'hFFFF_0000);
    w.kind = KIND_CLEAR;
    for (int p = 0; p < 6; p++) w.rd[p] = $urandom;
    send_word(w);
    send_word(clean_word(32'h0000_0007));
    w = clean_word(32'h0000_0007);
    w.rd[4][0] = ~w.rd[4][0];
    send_word(w);

    // zero threshold: every failing word is multi
    set_threshold(NBITS_W'(0));
    w = clean_word(32'h2468_ACE0);
    w.rd[3][12] = 1'b0;
    send_word(w);
    w = clean_word(32'h2468_ACE0);
    w.rd[2] = PAT_ONES;
    send_word(w);

    // above 32: every failing word is single
    set_threshold(NBITS_W'(63));
    w = clean_word(32'h1357_9BDF);
    w.rd[1][3] = ~w.rd[1][3];
    send_word(w);
    w = clean_word(32'h1357_9BDF);
    w.rd[5] = ~w.rd[5];
    send_word(w);

    set_threshold(NBITS_W'(32));
    w = clean_word(32'hFEDC_BA98);
    w.rd[2] = PAT_ONES;
    send_word(w);

    // Random phases, each under its own threshold; phase 2 runs without idling.
    phase_limits = '{NBITS_W'(1), NBITS_W'(3), NBITS_W'(0), NBITS_W'(32), NBITS_W'(33),
                     NBITS_W'($urandom_range(63)), NBITS_W'(63)};
    for (int ph = 0; ph < 7; ph++) begin
      set_threshold(phase_limits[ph]);
      idle_on = (ph != 2);
      repeat (RANDOM_WORDS / 7) send_word(random_word());
    end
    idle_on = 1'b1;

    // Restart the counters and finish with a short random tail.
    set_threshold(NBITS_W'($urandom_range(1, 63)));
    w = clean_word($urandom);
    w.kind = KIND_CLEAR;
    send_word(w);
    repeat (40) send_word(random_word());

    drain();
    repeat (8) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/stec_pkg.sv
rtl/core/stec_in_if.sv
rtl/core/stec_out_if.sv
rtl/core/stec_front.sv
rtl/core/stec_queue.sv
rtl/core/stec_back.sv
rtl/core/sram_test_error_classifier.sv
dv/tb_top.sv
